// ===== sv/tiac_pkg.sv =====
// Package for the telnet IAC flow classifier: codes, widths and byte checks.
`default_nettype none
package tiac_pkg;

	localparam int POSITION_BITS = 16;
	localparam int LIMIT_BITS    = 8;
	localparam int COUNT_BITS    = 16;
	localparam int CFG_IDX_BITS  = 2;

	typedef logic [1:0]               verdict_t;
	typedef logic [1:0]               stage_t;
	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam verdict_t VERDICT_IDENTIFIED   = 2'd0;
	localparam verdict_t VERDICT_INCONCLUSIVE = 2'd1;
	localparam verdict_t VERDICT_EXCLUDED     = 2'd2;

	localparam stage_t STAGE_NONE  = 2'd0;
	localparam stage_t STAGE_FINAL = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_STAGED_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNSTAGED_LIMIT = 2'd1;

	localparam logic [7:0] IAC          = 8'hff;
	localparam logic [7:0] CMD_HDR_MIN  = 8'hf9;
	localparam logic [7:0] OPT_HDR_LIM  = 8'h28;
	localparam logic [7:0] CMD_LOW      = 8'hf0;
	localparam logic [7:0] CMD_LOW_END  = 8'hfa;
	localparam logic [7:0] CMD_NEG      = 8'hfb;

	localparam pos_t POS_MAX = '1;

	// An IAC must open a plain command, or a negotiation command plus option.
	function automatic logic window_ok(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		logic ok;
		ok = 1'b0;
		if (b0 != IAC)
			ok = 1'b1;
		else if (b1 >= CMD_LOW && b1 <= CMD_LOW_END)
			ok = 1'b1;
		else if (b1 >= CMD_NEG && b1 != IAC && b2 <= OPT_HDR_LIM)
			ok = 1'b1;
		return ok;
	endfunction

endpackage
`default_nettype wire

// ===== sv/telnet_iac_flow_classifier_core.sv =====
// Telnet IAC flow classifier: per-byte header/window check and per-packet verdict.
//
//  channel | direction | handshake                | content
//  in      | request   | in_valid / in_ready      | payload_byte, last_byte, flow_stage,
//          |           |                          | packet_count
//  out     | result    | out_valid / out_ready    | verdict, new_stage (last byte only)
//  cfg     | write     | cfg_we                   | cfg_index, cfg_data
//
// One byte per cycle sustained while no last byte waits on a stalled result. A byte is held in the
// input stage, checked as a header byte or against the two stored bytes before it, and a last byte
// loads the result register; it leaves the input stage only when the result register is free.
// Reset clears the limits to 12 and 6 and the per-packet state.
// A stalled result holds only a last byte in the input stage; other bytes keep moving.
`default_nettype none
module telnet_iac_flow_classifier_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       payload_byte,
	input  wire logic                             last_byte,
	input  wire logic [1:0]                       flow_stage,
	input  wire logic [tiac_pkg::COUNT_BITS-1:0]  packet_count,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            verdict,
	output logic [1:0]                            new_stage,
	input  wire logic                             cfg_we,
	input  wire logic [tiac_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [tiac_pkg::LIMIT_BITS-1:0]  cfg_data
);
	import tiac_pkg::*;

	logic [LIMIT_BITS-1:0] staged_limit_q, unstaged_limit_q;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	stage_t                stage_s1;
	logic [COUNT_BITS-1:0] count_s1;

	pos_t       pos_q;
	logic [7:0] older_q, newer_q;
	logic       ok_q;

	verdict_t verdict_q;
	stage_t   new_stage_q;
	logic     out_valid_q;

	logic     out_free, adv_s1, chk_fail, ok_now, passed, keep_looking;
	verdict_t verdict_d;
	stage_t   stage_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staged_limit_q   <= LIMIT_BITS'(12);
			unstaged_limit_q <= LIMIT_BITS'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STAGED_LIMIT:   staged_limit_q   <= cfg_data;
				REG_UNSTAGED_LIMIT: unstaged_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= payload_byte;
			last_s1  <= last_byte;
			stage_s1 <= flow_stage;
			count_s1 <= packet_count;
		end
	end

	// header bytes at positions 0..2, sliding window once its start reaches 3
	always_comb begin
		chk_fail = 1'b0;
		if (pos_q == POSITION_BITS'(0))
			chk_fail = (byte_s1 != IAC);
		else if (pos_q == POSITION_BITS'(1))
			chk_fail = !(byte_s1 > CMD_HDR_MIN && byte_s1 != IAC);
		else if (pos_q == POSITION_BITS'(2))
			chk_fail = !(byte_s1 < OPT_HDR_LIM);
		else if (pos_q >= POSITION_BITS'(5))
			chk_fail = !window_ok(older_q, newer_q, byte_s1);
	end

	assign ok_now = ok_q && !chk_fail;
	assign passed = ok_now && (pos_q >= POSITION_BITS'(2));
	assign keep_looking =
		(count_s1 < COUNT_BITS'(staged_limit_q) && stage_s1 != STAGE_NONE) ||
		(count_s1 < COUNT_BITS'(unstaged_limit_q));

	always_comb begin
		stage_d = stage_s1;
		if (passed) begin
			if (stage_s1 >= STAGE_FINAL) begin
				verdict_d = VERDICT_IDENTIFIED;
				stage_d   = STAGE_FINAL;
			end else begin
				verdict_d = VERDICT_INCONCLUSIVE;
				stage_d   = stage_s1 + 2'd1;
			end
		end else begin
			verdict_d = keep_looking ? VERDICT_INCONCLUSIVE : VERDICT_EXCLUDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			older_q <= '0;
			newer_q <= '0;
			ok_q    <= 1'b1;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				older_q <= '0;
				newer_q <= '0;
				ok_q    <= 1'b1;
			end else begin
				older_q <= newer_q;
				newer_q <= byte_s1;
				ok_q    <= ok_now;
				if (pos_q != POS_MAX)
					pos_q <= pos_q + POSITION_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= adv_s1 && last_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			verdict_q   <= verdict_d;
			new_stage_q <= stage_d;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign new_stage = new_stage_q;

endmodule
`default_nettype wire

// ===== sv/tiac_checker.sv =====
// Port-level checks for the telnet IAC flow classifier, bound to the top level.
`default_nettype none
module tiac_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              last_byte,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [1:0]                        verdict,
	input wire logic [1:0]                        new_stage
);
	import tiac_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(new_stage))
		else $error("result changed while stalled");

	a_ident_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VERDICT_IDENTIFIED |-> new_stage == STAGE_FINAL)
		else $error("identified flow not at final stage");

	// with the result register empty nothing can block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a rising result traces back to a last byte accepted into the input stage
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
		else $error("result without a preceding last byte");

endmodule

bind telnet_iac_flow_classifier_core tiac_checker u_tiac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.verdict   (verdict),
	.new_stage (new_stage)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for telnet_iac_flow_classifier_core: packet stimulus, inline verdict predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tiac_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int IDLE_PCT     = 38;

	// indexes the block does not decode
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0]            data;
		logic                  last;
		stage_t                stage;
		logic [COUNT_BITS-1:0] count;
	} payload_req_t;

	typedef struct packed {
		verdict_t verdict;
		stage_t   stage;
	} verdict_rec_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic [7:0]              payload_byte = '0;
	logic                    last_byte    = 1'b0;
	logic [1:0]              flow_stage   = '0;
	logic [COUNT_BITS-1:0]   packet_count = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic [1:0]              verdict;
	logic [1:0]              new_stage;
	logic                    cfg_we       = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic [LIMIT_BITS-1:0]   cfg_data     = '0;

	telnet_iac_flow_classifier_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.last_byte(last_byte),
		.flow_stage(flow_stage),
		.packet_count(packet_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.new_stage(new_stage),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	payload_req_t byte_backlog[$];
	verdict_rec_t pending_verdicts[$];
	logic [7:0]   pkt_buf[$];

	// predictor copy of the per-packet state and the limits
	pos_t                  pkt_pos      = '0;
	logic [7:0]            prev2        = '0;
	logic [7:0]            prev1        = '0;
	logic                  seq_ok       = 1'b1;
	logic [LIMIT_BITS-1:0] lim_staged   = 8'd12;
	logic [LIMIT_BITS-1:0] lim_unstaged = 8'd6;

	int errors          = 0;
	int bytes_queued    = 0;
	int bytes_sent      = 0;
	int packets_checked = 0;
	int verdict_hits[3] = '{0, 0, 0};
	int cycles          = 0;

	logic no_idle   = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	initial forever #10 clk = ~clk;

	function automatic logic iac_window_legal(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		if (b0 != IAC)
			return 1'b1;
		if (b1 >= CMD_LOW && b1 <= CMD_LOW_END)
			return 1'b1;
		return (b1 >= CMD_NEG) && (b1 != IAC) && (b2 <= OPT_HDR_LIM);
	endfunction

	task automatic classify_byte(input logic [7:0] b, input logic last, input stage_t stg,
			input logic [COUNT_BITS-1:0] cnt);
		logic         chk;
		verdict_rec_t rec;
		chk = 1'b1;
		if (pkt_pos == 0)
			chk = (b == IAC);
		else if (pkt_pos == 1)
			chk = (b > CMD_HDR_MIN) && (b != IAC);
		else if (pkt_pos == 2)
			chk = (b < OPT_HDR_LIM);
		else if (pkt_pos >= 5)
			chk = iac_window_legal(prev2, prev1, b);
		if (!chk)
			seq_ok = 1'b0;
		if (!last) begin
			prev2 = prev1;
			prev1 = b;
			if (pkt_pos != POS_MAX)
				pkt_pos = pkt_pos + 1'b1;
		end else begin
			rec.stage = stg;
			if (seq_ok && pkt_pos >= 2) begin
				if (stg >= STAGE_FINAL) begin
					rec.verdict = VERDICT_IDENTIFIED;
					rec.stage   = STAGE_FINAL;
				end else begin
					rec.verdict = VERDICT_INCONCLUSIVE;
					rec.stage   = stg + 2'd1;
				end
			end else if ((cnt < lim_staged && stg != STAGE_NONE) || cnt < lim_unstaged) begin
				rec.verdict = VERDICT_INCONCLUSIVE;
			end else begin
				rec.verdict = VERDICT_EXCLUDED;
			end
			pending_verdicts.push_back(rec);
			pkt_pos = '0;
			prev2   = '0;
			prev1   = '0;
			seq_ok  = 1'b1;
		end
	endtask

	task automatic flag_mismatch(input string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	// request driver
	always @(posedge clk) begin
		payload_req_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				classify_byte(payload_byte, last_byte, flow_stage, packet_count);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (byte_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = byte_backlog.pop_front();
					in_valid     <= 1'b1;
					payload_byte <= nxt.data;
					last_byte    <= nxt.last;
					flow_stage   <= nxt.stage;
					packet_count <= nxt.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result-side ready, with one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// result monitor
	always @(posedge clk) begin
		verdict_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch($sformatf("unexpected result verdict %0d stage %0d",
					verdict, new_stage));
			end else begin
				want = pending_verdicts.pop_front();
				packets_checked++;
				if (want.verdict <= VERDICT_EXCLUDED)
					verdict_hits[want.verdict]++;
				if (verdict !== want.verdict)
					flag_mismatch($sformatf("verdict %0d, expected %0d (packet %0d)",
						verdict, want.verdict, packets_checked));
				if (new_stage !== want.stage)
					flag_mismatch($sformatf("new_stage %0d, expected %0d (packet %0d)",
						new_stage, want.stage, packets_checked));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_verdicts.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [LIMIT_BITS-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_STAGED_LIMIT)
			lim_staged = val;
		else if (idx == REG_UNSTAGED_LIMIT)
			lim_unstaged = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (bytes_sent != bytes_queued || pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic flush_packet(input stage_t stg, input logic [COUNT_BITS-1:0] cnt);
		payload_req_t req;
		foreach (pkt_buf[i]) begin
			req.data  = pkt_buf[i];
			req.last  = (i == pkt_buf.size() - 1);
			req.stage = req.last ? stg : stage_t'($urandom_range(0, 3));
			req.count = req.last ? cnt : COUNT_BITS'($urandom);
			byte_backlog.push_back(req);
		end
		bytes_queued += pkt_buf.size();
	endtask

	// legal IAC sequence: plain command, or negotiation command plus option
	task automatic push_iac_seq();
		pkt_buf.push_back(IAC);
		if ($urandom_range(0, 1)) begin
			pkt_buf.push_back(8'($urandom_range(CMD_LOW, CMD_LOW_END)));
		end else begin
			pkt_buf.push_back(8'($urandom_range(CMD_NEG, 8'hfe)));
			pkt_buf.push_back(8'($urandom_range(0, OPT_HDR_LIM)));
		end
	endtask

	// counts cluster around the current limits, with the full range now and then
	function automatic logic [COUNT_BITS-1:0] pick_count();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 35)
			return COUNT_BITS'($urandom_range(0, 65535));
		if (r < 65) begin
			v = ($urandom_range(0, 1) ? int'(lim_staged) : int'(lim_unstaged))
				+ $urandom_range(0, 2) - 1;
			return COUNT_BITS'((v < 0) ? 0 : v);
		end
		return COUNT_BITS'($urandom_range(0, 40));
	endfunction

	task automatic build_random_packet();
		int r;
		int len;
		int kind;
		int idx;
		r = $urandom_range(0, 99);
		if (r < 8)
			len = $urandom_range(1, 2);
		else if (r < 90)
			len = $urandom_range(3, 12);
		else
			len = $urandom_range(13, 40);
		kind = $urandom_range(0, 99);
		pkt_buf.delete();
		if (kind >= 88) begin
			repeat (len) pkt_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			pkt_buf.push_back(IAC);
			pkt_buf.push_back(8'($urandom_range(CMD_LOW_END, 8'hfe)));
			pkt_buf.push_back(8'($urandom_range(0, OPT_HDR_LIM - 1)));
			while (pkt_buf.size() < len) begin
				if ($urandom_range(0, 99) < 25)
					push_iac_seq();
				else
					pkt_buf.push_back(8'($urandom_range(0, 8'hfe)));
			end
			while (pkt_buf.size() > len)
				pkt_buf.delete(pkt_buf.size() - 1);
			// an IAC as the last byte never opens a checked window
			if (len >= 4 && $urandom_range(0, 99) < 30)
				pkt_buf[len - 1] = IAC;
			if (kind >= 70) begin
				idx = $urandom_range(0, len - 1);
				case ($urandom_range(0, 3))
					0: pkt_buf[idx] = IAC;
					1: pkt_buf[idx] = CMD_HDR_MIN;
					2: pkt_buf[idx] = OPT_HDR_LIM;
					default: pkt_buf[idx] = 8'($urandom_range(0, 255));
				endcase
			end
		end
	endtask

	task automatic random_bytes(input int n);
		int goal;
		goal = bytes_queued + n;
		while (bytes_queued < goal) begin
			build_random_packet();
			flush_packet(stage_t'($urandom_range(0, 3)), pick_count());
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short packets, header boundaries, tail IACs, stage 3
		pkt_buf = '{8'hff};
		flush_packet(2'd1, 16'd0);
		pkt_buf = '{8'hff, 8'hfb};
		flush_packet(2'd0, 16'hffff);
		pkt_buf = '{8'hff, 8'hfa, 8'h27};
		flush_packet(2'd0, 16'd6);
		pkt_buf = '{8'hff, 8'hf9, 8'h00};
		flush_packet(2'd2, 16'd11);
		pkt_buf = '{8'hff, 8'hfe, 8'h28};
		flush_packet(2'd0, 16'd5);
		pkt_buf = '{8'hff, 8'hff, 8'h00};
		flush_packet(2'd3, 16'd12);
		pkt_buf = '{8'hff, 8'hfc, 8'h00, 8'hff, 8'h00, 8'h00};
		flush_packet(2'd2, 16'd12);
		pkt_buf = '{8'hff, 8'hfb, 8'h01, 8'hff, 8'hfa, 8'h33, 8'hff, 8'hfe, 8'h28,
			8'hff, 8'hff};
		flush_packet(2'd3, 16'd0);
		random_bytes(100);
		wait_drained();

		write_reg(REG_STAGED_LIMIT, 8'd0);
		write_reg(REG_UNSTAGED_LIMIT, 8'd0);
		random_bytes(110);
		wait_drained();

		write_reg(REG_STAGED_LIMIT, 8'hff);
		write_reg(REG_UNSTAGED_LIMIT, 8'hff);
		no_idle <= 1'b1;
		random_bytes(110);
		wait_drained();
		no_idle <= 1'b0;

		write_reg(REG_SPARE_A, 8'h01);
		write_reg(REG_SPARE_B, 8'h02);
		write_reg(REG_STAGED_LIMIT, 8'($urandom_range(1, 254)));
		write_reg(REG_UNSTAGED_LIMIT, 8'($urandom_range(1, 254)));
		random_bytes(110);
		wait_drained();

		// results held back while the sender keeps pushing
		no_idle  <= 1'b1;
		hold_req <= 1'b1;
		random_bytes(100);
		wait_drained();

		$display("covered %0d payload bytes in %0d checked packets, with a long result stall",
			bytes_sent, packets_checked);
		$display("verdicts: %0d identified, %0d inconclusive, %0d excluded; limits swept 0..255",
			verdict_hits[0], verdict_hits[1], verdict_hits[2]);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
